// ----- design/selective_repeat_receive_window_macros.svh -----
// ---------------------------------------------------------------------------
// selective_repeat_receive_window_macros
// assertion helpers shared by the receive window rtl
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_MACROS_SVH

// condition implies consequence in the same cycle
`define SRW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define SRW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/srw_pkg.sv -----
// ---------------------------------------------------------------------------
// srw_pkg
// shared widths, defaults and codes of the selective repeat receive window
// ---------------------------------------------------------------------------
package srw_pkg;

	// default sizes
	localparam int MAX_SENDERS_DEF  = 16;
	localparam int WINDOW_SLOTS_DEF = 8;
	localparam int SEQ_SPACE_DEF    = 256;

	// fixed field widths
	localparam int ADDR_W     = 8;
	localparam int SEQ_IN_W   = 8;
	localparam int PAYLOAD_W  = 64;
	localparam int CFG_W      = 8;
	localparam int SENDERS_W  = 5;
	localparam int CFG_IDX_W  = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_ID    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SENDERS_IN_USE = 1'b1;

	localparam logic [SENDERS_W-1:0] SENDERS_RESET = 5'd16;

	// result kinds
	localparam logic KIND_ACK      = 1'b0;
	localparam logic KIND_DELIVERY = 1'b1;

endpackage

// ----- design/srw_payload_ram.sv -----
// ---------------------------------------------------------------------------
// srw_payload_ram
// buffered payload store, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module srw_payload_ram #(
	parameter int DEPTH  = srw_pkg::MAX_SENDERS_DEF * srw_pkg::WINDOW_SLOTS_DEF,
	parameter int DATA_W = srw_pkg::PAYLOAD_W,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/selective_repeat_receive_window.sv -----
// ---------------------------------------------------------------------------
// selective_repeat_receive_window
// selective repeat receiver with one window per sender: acks every kept
// frame, buffers new in-window frames and delivers the in-order prefix
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  frame     in         in_valid / in_stall   frame_ok, source_addr, dest_addr,
//                                             seq_num, payload_token
//  result    out        out_valid / out_stall result_kind, ack_*, delivered_*,
//                                             last_of_run
//  config    in         cfg_we               cfg_index, cfg_data
//
//  dropped frame: accepted in idle, nothing else. kept frame with no delivery:
//  accept, window lookup in the state memory, ack. with deliveries: then the
//  delivery loop, which reads one buffered payload per cycle from the
//  payload ram through its registered read, while out_stall allows.
//  reset: windows read as empty through per-sender valid bits, no clearing pass.
//  out_stall holds the loop; the frame side stalls until the frame is done.
// ---------------------------------------------------------------------------
`include "selective_repeat_receive_window_macros.svh"

module selective_repeat_receive_window #(
	parameter int MAX_SENDERS  = srw_pkg::MAX_SENDERS_DEF,
	parameter int WINDOW_SLOTS = srw_pkg::WINDOW_SLOTS_DEF,
	parameter int SEQ_SPACE    = srw_pkg::SEQ_SPACE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_we,
	input  logic [srw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srw_pkg::CFG_W-1:0]      cfg_data,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           frame_ok,
	input  logic [srw_pkg::ADDR_W-1:0]     source_addr,
	input  logic [srw_pkg::ADDR_W-1:0]     dest_addr,
	input  logic [srw_pkg::SEQ_IN_W-1:0]   seq_num,
	input  logic [srw_pkg::PAYLOAD_W-1:0]  payload_token,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           result_kind,
	output logic [srw_pkg::ADDR_W-1:0]     ack_src,
	output logic [srw_pkg::ADDR_W-1:0]     ack_dst,
	output logic [srw_pkg::SEQ_IN_W-1:0]   ack_seq,
	output logic [srw_pkg::PAYLOAD_W-1:0]  delivered_payload,
	output logic [srw_pkg::ADDR_W-1:0]     delivered_sender,
	output logic                           last_of_run
);

	localparam int SEQ_W     = $clog2(SEQ_SPACE);
	localparam int SLOT_W    = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int SND_W     = (MAX_SENDERS > 1) ? $clog2(MAX_SENDERS) : 1;
	localparam int ST_W      = SEQ_W + SLOT_W + WINDOW_SLOTS;
	localparam int PAY_DEPTH = MAX_SENDERS * WINDOW_SLOTS;
	localparam int PAY_AW    = (PAY_DEPTH > 1) ? $clog2(PAY_DEPTH) : 1;
	localparam int SEQ_IN_N  = 2 ** srw_pkg::SEQ_IN_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_ACK  = 4'b0100,
		ST_DLV  = 4'b1000
	} state_t;

	state_t state_q;

	// configuration
	logic [srw_pkg::ADDR_W-1:0]    rid_q;
	logic [srw_pkg::SENDERS_W-1:0] sui_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rid_q <= '0;
			sui_q <= srw_pkg::SENDERS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				srw_pkg::REG_RECEIVER_ID:    rid_q <= cfg_data;
				srw_pkg::REG_SENDERS_IN_USE: sui_q <= cfg_data[srw_pkg::SENDERS_W-1:0];
				default: ;
			endcase
		end
	end

	// captured frame
	logic [srw_pkg::ADDR_W-1:0]    src_q;
	logic [srw_pkg::ADDR_W-1:0]    dst_q;
	logic [srw_pkg::SEQ_IN_W-1:0]  seq_q;
	logic [srw_pkg::PAYLOAD_W-1:0] pay_q;
	logic [SND_W-1:0]              src_idx_q;

	logic accept;
	logic keep;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign keep     = frame_ok && (dest_addr == rid_q);

	// per-sender window state memory: {base, head, flags}
	logic [ST_W-1:0]        st_mem [MAX_SENDERS];
	logic [ST_W-1:0]        st_rd_q;
	logic                   st_vld_rd_q;
	logic [MAX_SENDERS-1:0] st_vld_q;
	logic                   st_we;
	logic [ST_W-1:0]        st_wdata;

	always_ff @(posedge clk) begin
		if (accept) begin
			st_rd_q <= st_mem[source_addr[SND_W-1:0]];
		end
		if (st_we) begin
			st_mem[src_idx_q] <= st_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q    <= '0;
			st_vld_rd_q <= 1'b0;
		end else begin
			if (accept) begin
				st_vld_rd_q <= st_vld_q[source_addr[SND_W-1:0]];
			end
			if (st_we) begin
				st_vld_q[src_idx_q] <= 1'b1;
			end
		end
	end

	// seq mod space table
	logic [SEQ_W-1:0] mod_tab [SEQ_IN_N];
	for (genvar g = 0; g < SEQ_IN_N; g++) begin : g_mod
		assign mod_tab[g] = SEQ_W'(g % SEQ_SPACE);
	end

	// window lookup
	logic [8:0]              limit;
	logic                    windowed;
	logic [SEQ_W-1:0]        base_rd;
	logic [SLOT_W-1:0]       head_rd;
	logic [WINDOW_SLOTS-1:0] flags_rd;
	logic [SEQ_W-1:0]        seq_mod;
	logic [SEQ_W:0]          diff;
	logic [SEQ_W-1:0]        off;
	logic                    slot_seen;
	logic                    in_win;
	logic                    hit;
	logic [WINDOW_SLOTS-1:0] new_flags;
	logic [SLOT_W:0]         slot_sum;
	logic [SLOT_W-1:0]       slot;

	always_comb begin
		limit = (9'(sui_q) > 9'(MAX_SENDERS)) ? 9'(MAX_SENDERS) : 9'(sui_q);
		windowed = 9'(src_q) < limit;

		base_rd  = st_vld_rd_q ? st_rd_q[WINDOW_SLOTS+SLOT_W +: SEQ_W] : '0;
		head_rd  = st_vld_rd_q ? st_rd_q[WINDOW_SLOTS +: SLOT_W] : '0;
		flags_rd = st_vld_rd_q ? st_rd_q[WINDOW_SLOTS-1:0] : '0;

		seq_mod = mod_tab[seq_q];
		diff = (SEQ_W+1)'(seq_mod) + (SEQ_W+1)'(SEQ_SPACE) - (SEQ_W+1)'(base_rd);
		if (diff >= (SEQ_W+1)'(SEQ_SPACE)) begin
			diff = diff - (SEQ_W+1)'(SEQ_SPACE);
		end
		off = diff[SEQ_W-1:0];

		in_win    = 32'(off) < 32'(WINDOW_SLOTS);
		// only meaningful while the offset is inside the window
		slot_seen = flags_rd[off[SLOT_W-1:0]];
		hit       = windowed && in_win && !slot_seen;
		new_flags = hit ? (flags_rd | (WINDOW_SLOTS'(1) << off)) : flags_rd;

		// ring position of the slot in this sender's payload area
		slot_sum = (SLOT_W+1)'(head_rd) + (SLOT_W+1)'(off);
		if (slot_sum >= (SLOT_W+1)'(WINDOW_SLOTS)) begin
			slot_sum = slot_sum - (SLOT_W+1)'(WINDOW_SLOTS);
		end
		slot = slot_sum[SLOT_W-1:0];
	end

	// working window state during delivery
	logic [SEQ_W-1:0]        base_q;
	logic [SLOT_W-1:0]       head_q;
	logic [WINDOW_SLOTS-1:0] flags_q;
	logic                    del_q;
	logic                    pend_q;
	logic                    pend_last_q;
	logic                    out_valid_q;

	logic [SEQ_W-1:0]        base_inc;
	logic [SLOT_W-1:0]       head_inc;
	logic [WINDOW_SLOTS-1:0] flags_nxt;
	logic                    out_free;
	logic                    more;
	logic                    pay_re;
	logic                    pay_we;
	logic                    dlv_done;
	logic                    load_ack;
	logic                    load_dlv;
	logic [PAY_AW-1:0]       pay_waddr;
	logic [PAY_AW-1:0]       pay_raddr;
	logic [srw_pkg::PAYLOAD_W-1:0] pay_rdata;

	always_comb begin
		base_inc = ((SEQ_W+1)'(base_q) + 1'b1 == (SEQ_W+1)'(SEQ_SPACE)) ? '0 : base_q + 1'b1;
		head_inc = ((SLOT_W+1)'(head_q) + 1'b1 == (SLOT_W+1)'(WINDOW_SLOTS)) ?
			'0 : head_q + 1'b1;
		flags_nxt = flags_q >> 1;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign more     = flags_q[0];
	assign pay_re   = (state_q == ST_DLV) && more && (!pend_q || out_free);
	assign dlv_done = (state_q == ST_DLV) && !more && (!pend_q || out_free);
	assign pay_we   = (state_q == ST_EVAL) && hit;
	assign load_ack = (state_q == ST_ACK) && out_free;
	assign load_dlv = (state_q == ST_DLV) && pend_q && out_free;

	assign st_we    = pay_we || dlv_done;
	assign st_wdata = (state_q == ST_EVAL) ? {base_rd, head_rd, new_flags}
	                                       : {base_q, head_q, flags_q};

	assign pay_waddr = PAY_AW'(src_idx_q) * PAY_AW'(WINDOW_SLOTS) + PAY_AW'(slot);
	assign pay_raddr = PAY_AW'(src_idx_q) * PAY_AW'(WINDOW_SLOTS) + PAY_AW'(head_q);

	srw_payload_ram #(
		.DEPTH  (PAY_DEPTH),
		.DATA_W (srw_pkg::PAYLOAD_W),
		.ADDR_W (PAY_AW)
	) u_payload_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (pay_q),
		.re    (pay_re),
		.raddr (pay_raddr),
		.rdata (pay_rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && keep) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: state_q <= ST_ACK;
				ST_ACK: begin
					if (load_ack) begin
						state_q <= del_q ? ST_DLV : ST_IDLE;
					end
				end
				ST_DLV: begin
					if (dlv_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// one payload read in flight, held in the ram output until taken
			pend_q <= pay_re || (pend_q && !out_free);

			if (load_ack || load_dlv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	logic                          kind_q;
	logic [srw_pkg::ADDR_W-1:0]    ack_src_q;
	logic [srw_pkg::ADDR_W-1:0]    ack_dst_q;
	logic [srw_pkg::SEQ_IN_W-1:0]  ack_seq_q;
	logic [srw_pkg::PAYLOAD_W-1:0] dpay_q;
	logic [srw_pkg::ADDR_W-1:0]    dsnd_q;
	logic                          last_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			src_q     <= source_addr;
			dst_q     <= dest_addr;
			seq_q     <= seq_num;
			pay_q     <= payload_token;
			src_idx_q <= source_addr[SND_W-1:0];
		end

		if (state_q == ST_EVAL) begin
			base_q  <= base_rd;
			head_q  <= head_rd;
			flags_q <= new_flags;
			del_q   <= hit && new_flags[0];
		end else if (pay_re) begin
			base_q      <= base_inc;
			head_q      <= head_inc;
			flags_q     <= flags_nxt;
			pend_last_q <= !flags_nxt[0];
		end

		if (load_ack) begin
			kind_q    <= srw_pkg::KIND_ACK;
			ack_src_q <= dst_q;
			ack_dst_q <= src_q;
			ack_seq_q <= seq_q;
			dpay_q    <= '0;
			dsnd_q    <= '0;
			last_q    <= !del_q;
		end else if (load_dlv) begin
			kind_q    <= srw_pkg::KIND_DELIVERY;
			ack_src_q <= '0;
			ack_dst_q <= '0;
			ack_seq_q <= '0;
			dpay_q    <= pay_rdata;
			dsnd_q    <= src_q;
			last_q    <= pend_last_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign result_kind       = kind_q;
	assign ack_src           = ack_src_q;
	assign ack_dst           = ack_dst_q;
	assign ack_seq           = ack_seq_q;
	assign delivered_payload = dpay_q;
	assign delivered_sender  = dsnd_q;
	assign last_of_run       = last_q;

	`SRW_ASSERT_NOW(a_no_read_overrun, pay_re && pend_q, out_free,
		"payload read would overwrite an untaken read")
	`SRW_ASSERT_NOW(a_write_not_pending, pay_we, !pend_q,
		"payload write while a delivery read is pending")
	`SRW_ASSERT_NEXT(a_kept_goes_eval, accept && keep, state_q == ST_EVAL,
		"kept frame did not start a window lookup")
	`SRW_ASSERT_NOW(a_idle_drained, state_q == ST_IDLE, !pend_q,
		"idle with a delivery still in flight")
	`SRW_ASSERT_NOW(a_write_windowed, st_we, windowed,
		"window state written for an unwindowed sender")

endmodule

// ----- tb/srw_window_checker.sv -----
// ---------------------------------------------------------------------------
// srw_window_checker
// watches the frame, result and config ports of the receive window, keeps
// its own copy of every sender's window and compares each result in order
// ---------------------------------------------------------------------------
module srw_window_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [srw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srw_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           frame_ok,
	input  logic [srw_pkg::ADDR_W-1:0]     source_addr,
	input  logic [srw_pkg::ADDR_W-1:0]     dest_addr,
	input  logic [srw_pkg::SEQ_IN_W-1:0]   seq_num,
	input  logic [srw_pkg::PAYLOAD_W-1:0]  payload_token,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           result_kind,
	input  logic [srw_pkg::ADDR_W-1:0]     ack_src,
	input  logic [srw_pkg::ADDR_W-1:0]     ack_dst,
	input  logic [srw_pkg::SEQ_IN_W-1:0]   ack_seq,
	input  logic [srw_pkg::PAYLOAD_W-1:0]  delivered_payload,
	input  logic [srw_pkg::ADDR_W-1:0]     delivered_sender,
	input  logic                           last_of_run,
	output int                             mismatches,
	output int                             awaited,
	output int                             acks_seen,
	output int                             deliveries_seen,
	output int                             longest_run
);
	timeunit 1ns;
	timeprecision 1ps;

	import srw_pkg::*;

	localparam int NSND = MAX_SENDERS_DEF;
	localparam int NSLOT = WINDOW_SLOTS_DEF;

	typedef struct packed {
		logic                 kind;
		logic [ADDR_W-1:0]    ack_src;
		logic [ADDR_W-1:0]    ack_dst;
		logic [SEQ_IN_W-1:0]  ack_seq;
		logic [PAYLOAD_W-1:0] payload;
		logic [ADDR_W-1:0]    sender;
		logic                 last_of_run;
	} window_result_t;

	window_result_t awaited_results[$];

	logic [ADDR_W-1:0]    own_id;
	logic [SENDERS_W-1:0] sender_count;
	logic [SEQ_IN_W-1:0]  base_seq [NSND];
	logic [NSLOT-1:0]     got_slot [NSND];
	logic [PAYLOAD_W-1:0] held_pay [NSND][NSLOT];

	function automatic int field_bad(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	function automatic void absorb_frame(logic ok, logic [ADDR_W-1:0] src,
			logic [ADDR_W-1:0] dst, logic [SEQ_IN_W-1:0] seq, logic [PAYLOAD_W-1:0] pay);
		window_result_t r;
		logic [NSLOT-1:0] flags;
		int limit;
		int off;
		int run;
		if (!ok || dst != own_id)
			return;
		r = '0;
		r.kind = KIND_ACK;
		r.ack_src = dst;
		r.ack_dst = src;
		r.ack_seq = seq;
		awaited_results.push_back(r);
		acks_seen++;
		limit = (int'(sender_count) > NSND) ? NSND : int'(sender_count);
		if (int'(src) < limit) begin
			off = (int'(seq) % SEQ_SPACE_DEF + SEQ_SPACE_DEF - int'(base_seq[src]))
				% SEQ_SPACE_DEF;
			flags = got_slot[src];
			if (off < NSLOT && !flags[off]) begin
				flags[off] = 1'b1;
				held_pay[src][off] = pay;
				run = 0;
				while (run < NSLOT && flags[run]) begin
					r = '0;
					r.kind = KIND_DELIVERY;
					r.payload = held_pay[src][run];
					r.sender = src;
					awaited_results.push_back(r);
					deliveries_seen++;
					run++;
				end
				if (run > longest_run)
					longest_run = run;
				// slide the window past the delivered prefix
				if (run > 0) begin
					for (int k = 0; k < NSLOT; k++)
						held_pay[src][k] = (k + run < NSLOT) ? held_pay[src][k + run] : '0;
					flags = flags >> run;
					base_seq[src] = SEQ_IN_W'((int'(base_seq[src]) + run) % SEQ_SPACE_DEF);
				end
				got_slot[src] = flags;
			end
		end
		awaited_results[awaited_results.size() - 1].last_of_run = 1'b1;
	endfunction

	function automatic void compare_result();
		window_result_t w;
		if (awaited_results.size() == 0) begin
			$error("result with nothing awaited: kind %0d", result_kind);
			mismatches++;
			return;
		end
		w = awaited_results.pop_front();
		mismatches += field_bad("result_kind", 64'(w.kind), 64'(result_kind));
		mismatches += field_bad("ack_src", 64'(w.ack_src), 64'(ack_src));
		mismatches += field_bad("ack_dst", 64'(w.ack_dst), 64'(ack_dst));
		mismatches += field_bad("ack_seq", 64'(w.ack_seq), 64'(ack_seq));
		mismatches += field_bad("delivered_payload", w.payload, delivered_payload);
		mismatches += field_bad("delivered_sender", 64'(w.sender), 64'(delivered_sender));
		mismatches += field_bad("last_of_run", 64'(w.last_of_run), 64'(last_of_run));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_results.delete();
			own_id = '0;
			sender_count = SENDERS_RESET;
			for (int s = 0; s < NSND; s++) begin
				base_seq[s] = '0;
				got_slot[s] = '0;
				for (int k = 0; k < NSLOT; k++)
					held_pay[s][k] = '0;
			end
			mismatches = 0;
			awaited = 0;
			acks_seen = 0;
			deliveries_seen = 0;
			longest_run = 0;
		end else begin
			if (out_valid && !out_stall)
				compare_result();
			if (in_valid && !in_stall)
				absorb_frame(frame_ok, source_addr, dest_addr, seq_num, payload_token);
			if (cfg_we) begin
				if (cfg_index == REG_RECEIVER_ID)
					own_id = cfg_data;
				else if (cfg_index == REG_SENDERS_IN_USE)
					sender_count = cfg_data[SENDERS_W-1:0];
			end
			awaited = awaited_results.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// stimulus for the selective repeat receive window: directed corner frames,
// then shuffled in-window request bursts mixed with dropped, unwindowed and
// out-of-window frames under several receiver and sender settings
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import srw_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 frame_ok;
	logic [ADDR_W-1:0]    source_addr;
	logic [ADDR_W-1:0]    dest_addr;
	logic [SEQ_IN_W-1:0]  seq_num;
	logic [PAYLOAD_W-1:0] payload_token;
	logic                 out_valid;
	logic                 out_stall;
	logic                 result_kind;
	logic [ADDR_W-1:0]    ack_src;
	logic [ADDR_W-1:0]    ack_dst;
	logic [SEQ_IN_W-1:0]  ack_seq;
	logic [PAYLOAD_W-1:0] delivered_payload;
	logic [ADDR_W-1:0]    delivered_sender;
	logic                 last_of_run;

	int mismatches;
	int awaited;
	int acks_seen;
	int deliveries_seen;
	int longest_run;

	logic                 calm = 1'b0;
	logic [ADDR_W-1:0]    rx_cur;
	int                   senders_cur;
	int                   frames_sent = 0;
	int                   kept = 0;
	logic [SEQ_IN_W-1:0]  next_base [MAX_SENDERS_DEF];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	selective_repeat_receive_window i_dut (.*);

	srw_window_checker i_checker (.*);

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// result side back-pressure
	initial begin
		int left;
		logic hold;
		left = 0;
		hold = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				hold = 1'b0;
				left = 0;
			end else if (left == 0) begin
				hold = ($urandom_range(0, 2) == 0);
				left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
					: $urandom_range(8, 30);
			end else begin
				left--;
			end
			out_stall <= hold;
		end
	end

	task automatic offer(logic ok, logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
			logic [SEQ_IN_W-1:0] seq, logic [PAYLOAD_W-1:0] pay);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		frame_ok <= ok;
		source_addr <= src;
		dest_addr <= dst;
		seq_num <= seq;
		payload_token <= pay;
		do @(posedge clk); while (in_stall);
		frames_sent++;
		if (ok && dst == rx_cur)
			kept++;
	endtask

	// sender holds off until every awaited result is out
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_RECEIVER_ID)
			rx_cur = val;
		else
			senders_cur = int'(val[SENDERS_W-1:0]);
	endtask

	function automatic int windowed_limit();
		return (senders_cur > MAX_SENDERS_DEF) ? MAX_SENDERS_DEF : senders_cur;
	endfunction

	// up to one window's worth of new frames in shuffled order, a few repeated
	task automatic window_burst(logic [ADDR_W-1:0] src);
		int order [WINDOW_SLOTS_DEF];
		int n;
		int j;
		int t;
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
			: $urandom_range(4, WINDOW_SLOTS_DEF);
		for (int k = 0; k < WINDOW_SLOTS_DEF; k++)
			order[k] = k;
		for (int k = n - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = order[k];
			order[k] = order[j];
			order[j] = t;
		end
		for (int k = 0; k < n; k++) begin
			offer(1'b1, src, rx_cur, next_base[src] + SEQ_IN_W'(order[k]), rand64());
			if ($urandom_range(0, 9) == 0)
				offer(1'b1, src, rx_cur, next_base[src] + SEQ_IN_W'(order[k]), rand64());
		end
		next_base[src] = next_base[src] + SEQ_IN_W'(n);
	endtask

	task automatic noise_frame();
		int lim;
		int r;
		logic [ADDR_W-1:0] src;
		lim = windowed_limit();
		r = $urandom_range(0, 4);
		if (r == 3 && lim == 0)
			r = 2;
		if (r == 2 && lim >= 256)
			r = 1;
		case (r)
			0: offer(1'b0, ADDR_W'($urandom), ADDR_W'($urandom), SEQ_IN_W'($urandom),
				rand64());
			1: offer(1'b1, ADDR_W'($urandom), rx_cur ^ ADDR_W'($urandom_range(1, 255)),
				SEQ_IN_W'($urandom), rand64());
			2: offer(1'b1, ADDR_W'($urandom_range(lim, 255)), rx_cur, SEQ_IN_W'($urandom),
				rand64());
			3: begin
				src = ADDR_W'($urandom_range(0, lim - 1));
				offer(1'b1, src, rx_cur,
					next_base[src] + SEQ_IN_W'($urandom_range(WINDOW_SLOTS_DEF, 255)),
					rand64());
			end
			default: offer(1'b1, ADDR_W'($urandom), rx_cur, SEQ_IN_W'($urandom), rand64());
		endcase
	endtask

	task automatic random_phase(logic [CFG_W-1:0] rx, logic [CFG_W-1:0] senders, int target,
			logic quiet);
		int goal;
		int lim;
		settle();
		write_reg(REG_RECEIVER_ID, rx);
		write_reg(REG_SENDERS_IN_USE, senders);
		calm = quiet;
		goal = kept + target;
		while (kept < goal) begin
			lim = windowed_limit();
			if (lim == 0 || $urandom_range(0, 4) == 0)
				noise_frame();
			else
				window_burst(ADDR_W'($urandom_range(0, lim - 1)));
		end
		calm = 1'b0;
	endtask

	initial begin
		int waited;
		logic leftover;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		frame_ok = 1'b0;
		source_addr = '0;
		dest_addr = '0;
		seq_num = '0;
		payload_token = '0;
		rx_cur = '0;
		senders_cur = int'(SENDERS_RESET);
		leftover = 1'b0;
		for (int s = 0; s < MAX_SENDERS_DEF; s++)
			next_base[s] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed corners under the reset settings
		offer(1'b0, 8'd0, 8'd0, 8'd0, '1);
		offer(1'b1, 8'd0, 8'hFF, 8'd0, '1);
		offer(1'b1, 8'd0, 8'd0, 8'd1, '1);
		offer(1'b1, 8'd0, 8'd0, 8'd1, 64'h1234);
		offer(1'b1, 8'd0, 8'd0, 8'd0, '0);
		offer(1'b1, 8'd0, 8'd0, 8'd200, rand64());
		offer(1'b1, 8'd0, 8'd0, 8'd1, rand64());
		offer(1'b1, 8'hFF, 8'd0, 8'hFF, rand64());
		offer(1'b1, 8'd16, 8'd0, 8'd0, rand64());
		// whole window filled back to front: the last frame brings an ack plus eight deliveries
		for (int k = WINDOW_SLOTS_DEF - 1; k >= 0; k--)
			offer(1'b1, 8'd15, 8'd0, SEQ_IN_W'(k), rand64());
		offer(1'b1, 8'd13, 8'd0, 8'd7, rand64());
		offer(1'b1, 8'd13, 8'd0, 8'd8, rand64());
		settle();
		write_reg(REG_RECEIVER_ID, 8'hFF);
		write_reg(REG_SENDERS_IN_USE, 8'd0);
		offer(1'b1, 8'd0, 8'hFF, 8'd2, rand64());
		settle();
		write_reg(REG_SENDERS_IN_USE, 8'd17);
		offer(1'b1, 8'd15, 8'hFF, 8'd8, rand64());
		next_base[0] = 8'd2;
		next_base[15] = 8'd9;

		random_phase(8'h5A, 8'd16, 45, 1'b0);
		random_phase(8'hFF, 8'd1, 35, 1'b1);
		random_phase(8'h00, 8'd7, 45, 1'b0);
		random_phase(8'h81, 8'hFF, 50, 1'b0);

		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (awaited != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		if (awaited != 0) begin
			$error("%0d results never arrived", awaited);
			leftover = 1'b1;
		end
		repeat (20) @(negedge clk);

		$display("frames sent %0d, kept %0d; acks %0d, in-order deliveries %0d",
			frames_sent, kept, acks_seen, deliveries_seen);
		$display("longest delivered run %0d, mismatches %0d", longest_run, mismatches);
		if (mismatches == 0 && !leftover) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/srw_pkg.sv
design/srw_payload_ram.sv
design/selective_repeat_receive_window.sv
tb/srw_window_checker.sv
tb/tb_top.sv
